/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");
`define PSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define PSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* design/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and types of the point to segment distance block.
// ----------------------------------------------------------------------------
`default_nettype none
package psd_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    typedef enum logic [1:0] {
        REG_START    = 2'd0,
        REG_END      = 2'd1,
        REG_INTERIOR = 2'd2
    } t_region;

    typedef struct packed {
        logic    valid;
        t_region region;
    } t_tag;
endpackage
`default_nettype wire

/* design/psd_stream_if.sv */
// ----------------------------------------------------------------------------
// psd_stream_if
// Valid/ready channels for query transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none
interface psd_in_if #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                    input ready);
    modport sink (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                  output ready);
endinterface

interface psd_out_if #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = psd_pkg::FRAC_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic [COORD_WIDTH+FRAC_BITS:0]     distance_fixed;
    logic [1:0]                         nearest_region;

    modport source (output valid, distance_fixed, nearest_region, input ready);
    modport sink (input valid, distance_fixed, nearest_region, output ready);
endinterface
`default_nettype wire

/* design/psd_front.sv */
// ----------------------------------------------------------------------------
// psd_front
// Four-stage front end: differences, products, region select, squaring.
// Produces the scaled numerator and denominator for the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none
module psd_front #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = psd_pkg::FRAC_BITS_DEF,
    localparam int DIFW = COORD_WIDTH + 1,
    localparam int PW   = 2 * DIFW,
    localparam int SW   = PW + 1,
    localparam int BW   = 2 * COORD_WIDTH + 2,
    localparam int DW   = COORD_WIDTH + FRAC_BITS + 1,
    localparam int QW   = 2 * DW,
    localparam int NW   = 2 * BW + 2 * FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic signed [COORD_WIDTH-1:0] i_px,
    input  wire logic signed [COORD_WIDTH-1:0] i_py,
    input  wire logic signed [COORD_WIDTH-1:0] i_ax,
    input  wire logic signed [COORD_WIDTH-1:0] i_ay,
    input  wire logic signed [COORD_WIDTH-1:0] i_bx,
    input  wire logic signed [COORD_WIDTH-1:0] i_by,
    output psd_pkg::t_tag                      o_tag,
    output logic [BW-1:0]                      o_rem,
    output logic [BW-1:0]                      o_den,
    output logic [QW-1:0]                      o_lo
);
    // stage 1: differences
    logic                   r_v1;
    logic signed [DIFW-1:0] r_dx, r_dy, r_wx, r_wy, r_ex, r_ey;
    // stage 2: products
    logic                   r_v2;
    logic signed [PW-1:0]   r_wxdx, r_wydy, r_wxdy, r_wydx;
    logic signed [PW-1:0]   r_dx2, r_dy2, r_wx2, r_wy2, r_ex2, r_ey2;
    // stage 3: region and operands
    psd_pkg::t_tag          r_tag3;
    logic [BW-1:0]          r_base;
    logic [BW-1:0]          r_den3;
    // stage 4: square and scale
    psd_pkg::t_tag          r_tag4;
    logic [NW-1:0]          r_num;
    logic [BW-1:0]          r_den4;

    logic signed [SW-1:0]   proj, cross_w, len2s, na, nb, abs_cross;
    psd_pkg::t_region       region;
    logic [2*BW-1:0]        sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_tag3.valid <= 1'b0;
            r_tag4.valid <= 1'b0;
        end else if (i_en) begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_tag3 <= '{valid: r_v2, region: region};
            r_tag4 <= r_tag3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= DIFW'(i_bx) - DIFW'(i_ax);
            r_dy <= DIFW'(i_by) - DIFW'(i_ay);
            r_wx <= DIFW'(i_px) - DIFW'(i_ax);
            r_wy <= DIFW'(i_py) - DIFW'(i_ay);
            r_ex <= DIFW'(i_px) - DIFW'(i_bx);
            r_ey <= DIFW'(i_py) - DIFW'(i_by);

            r_wxdx <= PW'(r_wx) * PW'(r_dx);
            r_wydy <= PW'(r_wy) * PW'(r_dy);
            r_wxdy <= PW'(r_wx) * PW'(r_dy);
            r_wydx <= PW'(r_wy) * PW'(r_dx);
            r_dx2  <= PW'(r_dx) * PW'(r_dx);
            r_dy2  <= PW'(r_dy) * PW'(r_dy);
            r_wx2  <= PW'(r_wx) * PW'(r_wx);
            r_wy2  <= PW'(r_wy) * PW'(r_wy);
            r_ex2  <= PW'(r_ex) * PW'(r_ex);
            r_ey2  <= PW'(r_ey) * PW'(r_ey);

            case (region)
                psd_pkg::REG_START: begin
                    r_base <= BW'(na);
                    r_den3 <= BW'(1);
                end
                psd_pkg::REG_END: begin
                    r_base <= BW'(nb);
                    r_den3 <= BW'(1);
                end
                default: begin
                    r_base <= BW'(abs_cross);
                    r_den3 <= BW'(len2s);
                end
            endcase

            r_num  <= NW'(sq) << (2 * FRAC_BITS);
            r_den4 <= r_den3;
        end
    end

    always_comb begin
        proj      = SW'(r_wxdx) + SW'(r_wydy);
        cross_w   = SW'(r_wxdy) - SW'(r_wydx);
        len2s     = SW'(r_dx2) + SW'(r_dy2);
        na        = SW'(r_wx2) + SW'(r_wy2);
        nb        = SW'(r_ex2) + SW'(r_ey2);
        abs_cross = cross_w[SW-1] ? -cross_w : cross_w;
        if (proj <= 0) begin
            region = psd_pkg::REG_START;
        end else if (proj >= len2s) begin
            region = psd_pkg::REG_END;
        end else begin
            region = psd_pkg::REG_INTERIOR;
        end
        if (r_tag3.region == psd_pkg::REG_INTERIOR) begin
            sq = r_base * r_base;
        end else begin
            sq = (2*BW)'(r_base);
        end
    end

    assign o_tag = r_tag4;
    assign o_rem = r_num[NW-1:QW];
    assign o_lo  = r_num[QW-1:0];
    assign o_den = r_den4;
endmodule
`default_nettype wire

/* design/psd_div_cell.sv */
// ----------------------------------------------------------------------------
// psd_div_cell
// One restoring division step: yields one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module psd_div_cell #(
    parameter int LW = 34,
    parameter int QW = 50
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire psd_pkg::t_tag i_tag,
    input  wire logic [LW-1:0] i_rem,
    input  wire logic [LW-1:0] i_den,
    input  wire logic [QW-1:0] i_lo,
    output psd_pkg::t_tag      o_tag,
    output logic [LW-1:0]      o_rem,
    output logic [LW-1:0]      o_den,
    output logic [QW-1:0]      o_lo
);
    psd_pkg::t_tag  r_tag;
    logic [LW-1:0]  r_rem, r_den;
    logic [QW-1:0]  r_lo;
    logic [LW:0]    trial, diff;
    logic           ge;

    always_comb begin
        trial = {i_rem, i_lo[QW-1]};
        diff  = trial - {1'b0, i_den};
        ge    = trial >= {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= ge ? diff[LW-1:0] : trial[LW-1:0];
            r_den <= i_den;
            r_lo  <= {i_lo[QW-2:0], ge};
        end
    end

    assign o_tag = r_tag;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_lo  = r_lo;
endmodule
`default_nettype wire

/* design/psd_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// One digit-by-digit square root step: yields one root bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module psd_sqrt_cell #(
    parameter int DW = 25,
    localparam int QW = 2 * DW,
    localparam int RW = DW + 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire psd_pkg::t_tag i_tag,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [DW-1:0] i_root,
    input  wire logic [QW-1:0] i_lo,
    output psd_pkg::t_tag      o_tag,
    output logic [RW-1:0]      o_rem,
    output logic [DW-1:0]      o_root,
    output logic [QW-1:0]      o_lo
);
    psd_pkg::t_tag  r_tag;
    logic [RW-1:0]  r_rem;
    logic [DW-1:0]  r_root;
    logic [QW-1:0]  r_lo;
    logic [RW-1:0]  acc, trial;
    logic           ge;

    always_comb begin
        acc   = {i_rem[RW-3:0], i_lo[QW-1:QW-2]};
        trial = RW'({i_root, 2'b01});
        ge    = acc >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= ge ? acc - trial : acc;
            r_root <= {i_root[DW-2:0], ge};
            r_lo   <= {i_lo[QW-3:0], 2'b00};
        end
    end

    assign o_tag  = r_tag;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_lo   = r_lo;
endmodule
`default_nettype wire

/* design/point_segment_distance.sv */
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a point to a segment, floored fixed point, with region code.
// ----------------------------------------------------------------------------
// Accepts one query transaction per cycle while the skid register is empty
// (ready is low while it is full) and returns one result per query, in
// order. A query passes a four-stage front end, a chain of 2*DW restoring
// divider cells (one quotient bit each) and a chain of DW square root cells
// (one root bit each), where DW = COORD_WIDTH + FRAC_BITS + 1; the result is
// presented straight from the last cell. A one-entry skid register behind
// the last cell keeps input accepted in the first cycle of a consumer stall;
// the whole chain then holds until the skid entry is taken.
`default_nettype none
`include "assert_macros.svh"
module point_segment_distance #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = psd_pkg::FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    psd_in_if.sink    i_in,
    psd_out_if.source o_out
);
    localparam int BW = 2 * COORD_WIDTH + 2;
    localparam int DW = COORD_WIDTH + FRAC_BITS + 1;
    localparam int QW = 2 * DW;
    localparam int RW = DW + 3;

    logic          en;
    logic          r_skid_v;
    logic [DW-1:0] r_skid_dist;
    logic [1:0]    r_skid_region;

    psd_pkg::t_tag div_tag  [0:QW];
    logic [BW-1:0] div_rem  [0:QW];
    logic [BW-1:0] div_den  [0:QW];
    logic [QW-1:0] div_lo   [0:QW];

    psd_pkg::t_tag sq_tag   [0:DW];
    logic [RW-1:0] sq_rem   [0:DW];
    logic [DW-1:0] sq_root  [0:DW];
    logic [QW-1:0] sq_lo    [0:DW];

    assign en         = !r_skid_v;
    assign i_in.ready = en;

    psd_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(i_in.valid),
        .i_px   (i_in.point_x),
        .i_py   (i_in.point_y),
        .i_ax   (i_in.start_x),
        .i_ay   (i_in.start_y),
        .i_bx   (i_in.end_x),
        .i_by   (i_in.end_y),
        .o_tag  (div_tag[0]),
        .o_rem  (div_rem[0]),
        .o_den  (div_den[0]),
        .o_lo   (div_lo[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_div
        psd_div_cell #(
            .LW(BW),
            .QW(QW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_tag  (div_tag[g]),
            .i_rem  (div_rem[g]),
            .i_den  (div_den[g]),
            .i_lo   (div_lo[g]),
            .o_tag  (div_tag[g+1]),
            .o_rem  (div_rem[g+1]),
            .o_den  (div_den[g+1]),
            .o_lo   (div_lo[g+1])
        );
    end

    assign sq_tag[0]  = div_tag[QW];
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_lo[0]   = div_lo[QW];

    for (genvar g = 0; g < DW; g++) begin : g_sqrt
        psd_sqrt_cell #(
            .DW(DW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_tag  (sq_tag[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .i_lo   (sq_lo[g]),
            .o_tag  (sq_tag[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1]),
            .o_lo   (sq_lo[g+1])
        );
    end

    // skid holds the last cell's transaction when the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_out.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (sq_tag[DW].valid && !o_out.ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid_dist   <= sq_root[DW];
            r_skid_region <= sq_tag[DW].region;
        end
    end

    assign o_out.valid          = r_skid_v || sq_tag[DW].valid;
    assign o_out.distance_fixed = r_skid_v ? r_skid_dist : sq_root[DW];
    assign o_out.nearest_region = r_skid_v ? r_skid_region : sq_tag[DW].region;

    `PSD_ASSERT_NEXT(a_skid_hold, i_clk, i_rst_n, r_skid_v && !o_out.ready, r_skid_v && $stable(r_skid_dist))
    `PSD_ASSERT_NEXT(a_chain_frozen, i_clk, i_rst_n, r_skid_v && !o_out.ready, $stable(sq_root[DW]))
    `PSD_ASSERT_IMPL(a_region_code, i_clk, i_rst_n, o_out.valid, o_out.nearest_region <= psd_pkg::REG_INTERIOR)
endmodule
`default_nettype wire
